### design/qai_pkg.sv
// Shared types and constants for the quaternion attitude integrator.
// Holds the unit status struct, operand widths and the product term table.
// No dependencies.
`default_nettype none

package qai_pkg;

  // Multiplicand width of the shared multiplier (rate product and its sign)
  localparam int unsigned MUL_A_W = 34;
  // Radicand and root widths of the square root unit
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned ROOT_W  = 32;

  // Rate vector selects
  localparam logic [1:0] W_X = 2'd0;
  localparam logic [1:0] W_Y = 2'd1;
  localparam logic [1:0] W_Z = 2'd2;

  // Quaternion component selects
  localparam logic [1:0] Q_R = 2'd0;
  localparam logic [1:0] Q_I = 2'd1;
  localparam logic [1:0] Q_J = 2'd2;
  localparam logic [1:0] Q_K = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic [1:0] w_sel;
    logic [1:0] q_sel;
    logic       neg;
  } term_t;

  // One term of the product (0, w) * q: output component, term index
  function automatic term_t term_of(input logic [1:0] comp, input logic [1:0] term);
    term_t t;
    unique case ({comp, term})
      {Q_R, 2'd0}: t = '{W_X, Q_I, 1'b1};
      {Q_R, 2'd1}: t = '{W_Y, Q_J, 1'b1};
      {Q_R, 2'd2}: t = '{W_Z, Q_K, 1'b1};
      {Q_I, 2'd0}: t = '{W_X, Q_R, 1'b0};
      {Q_I, 2'd1}: t = '{W_Y, Q_K, 1'b0};
      {Q_I, 2'd2}: t = '{W_Z, Q_J, 1'b1};
      {Q_J, 2'd0}: t = '{W_Y, Q_R, 1'b0};
      {Q_J, 2'd1}: t = '{W_Z, Q_I, 1'b0};
      {Q_J, 2'd2}: t = '{W_X, Q_K, 1'b1};
      {Q_K, 2'd0}: t = '{W_Z, Q_R, 1'b0};
      {Q_K, 2'd1}: t = '{W_X, Q_J, 1'b0};
      {Q_K, 2'd2}: t = '{W_Y, Q_I, 1'b1};
      default:     t = '{W_X, Q_R, 1'b0};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### design/qai_mul.sv
// Iterative signed shift-add multiplier, one multiplier bit per cycle.
// Depends on qai_pkg for the multiplicand width and status struct.
`default_nettype none

module qai_mul import qai_pkg::*; #(
  parameter int unsigned B_W = 17
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [MUL_A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]         b,
  output unit_stat_t                         stat,
  output logic signed [MUL_A_W+B_W-1:0]      prod
);

  localparam int unsigned P_W   = MUL_A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W);

  logic signed [P_W-1:0] mcand;
  logic [B_W-1:0]        mplier;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic                  last;

  assign last = (cnt == CNT_W'(B_W - 1));

  // Add one shifted partial product per cycle; the top bit weighs negative
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mcand  <= P_W'(a);
        mplier <= b;
        cnt    <= '0;
        prod   <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= last ? prod - mcand : prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

### design/qai_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on qai_pkg for widths and the status struct.
`default_nettype none

module qai_isqrt import qai_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  rad,
  output unit_stat_t             stat,
  output logic [ROOT_W-1:0]      root
);

  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] res;
  logic [4:0]       k;
  logic             busy;
  logic             done;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W-1:0] trial;

  // Test bit walks down from bit 62 two places per step
  assign bitv  = RAD_W'(1) << (6'd62 - {k, 1'b0});
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= rad;
        res  <= '0;
        k    <= '0;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        k <= k + 1'b1;
        if (k == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign root = res[ROOT_W-1:0];

endmodule

`default_nettype wire

### design/qai_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on qai_pkg for the divisor width and status struct.
`default_nettype none

module qai_div import qai_pkg::*; #(
  parameter int unsigned NUM_W = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [ROOT_W-1:0] den,
  output unit_stat_t             stat,
  output logic [NUM_W-1:0]       quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [ROOT_W-1:0] rem;
  logic [ROOT_W-1:0] dvs;
  logic [NUM_W-1:0]  numsh;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [ROOT_W:0]   trial;
  logic [ROOT_W:0]   diff;
  logic              fits;

  assign trial = {rem, numsh[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  // Shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        dvs   <= den;
        numsh <= num;
        quot  <= '0;
        cnt   <= '0;
      end else if (busy) begin
        rem   <= fits ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
        quot  <= {quot[NUM_W-2:0], fits};
        numsh <= numsh << 1;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

`default_nettype wire

### design/quaternion_attitude_integrator_core.sv
// Quaternion attitude integrator: sequencer, state registers and output stage.
// Depends on qai_pkg, qai_mul, qai_isqrt and qai_div.
//
// Usage: one input transaction (valid/ready) carries an action. A load sets
// the stored quaternion from the Q1.14 load fields. An integrate applies
// q += (0, rate*step) * q / 2, saturates, then renormalizes by an inverse
// square root; a squared norm below one LSB forces the real part to one and
// raises degenerate. Every transaction returns one result transaction with
// the stored quaternion in Q1.14.
// Sequence: a load goes through S_DONE to the output register. An integrate
// runs 19 multiplies on the shared shift-add multiplier
// (MB = max(COMPONENT_BITS, 17)), up to 24 normalizing shifts, one square
// root and four divides before S_DONE.
// One transaction is in flight at a time; in_ready is high only while idle.
// A finished result sits in the output register until taken; the next input
// may be accepted meanwhile, and its result waits if the receiver stalls.
// Reset (synchronous) sets the quaternion to (1, 0, 0, 0) and clears valid.
`default_nettype none

module quaternion_attitude_integrator_core import qai_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic signed [15:0] rate_x,
  input  wire logic signed [15:0] rate_y,
  input  wire logic signed [15:0] rate_z,
  input  wire logic [15:0]        step_time,
  input  wire logic signed [15:0] load_real,
  input  wire logic signed [15:0] load_i,
  input  wire logic signed [15:0] load_j,
  input  wire logic signed [15:0] load_k,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_real,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_j,
  output logic signed [15:0]      out_k,
  output logic                    degenerate
);

  localparam int unsigned C    = COMPONENT_BITS;
  localparam int unsigned FRAC = C - 2;
  localparam int unsigned MB   = (C > 17) ? C : 17;
  localparam int unsigned PW   = MUL_A_W + MB;
  localparam int unsigned AW   = PW + 2;
  localparam int unsigned NW   = 2 * C - 1;
  localparam int unsigned SH_W = 34;
  localparam int unsigned DW   = C + 32;
  localparam int unsigned DUP  = (C > 16) ? C - 16 : 0;
  localparam int unsigned DDN  = (C < 16) ? 16 - C : 0;

  localparam logic signed [C-1:0]  CMAX_C = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0]  CMIN_C = {1'b1, {(C-1){1'b0}}};
  localparam logic signed [C-1:0]  ONE_C  = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [AW-1:0] HALF   = {{(AW-26){1'b0}}, 1'b1, 25'd0};
  localparam logic [NW-1:0]        N_MIN  = NW'(1) << (C - 4);
  localparam logic [RAD_W-1:0]     M_LOW  = RAD_W'(1) << 60;
  localparam logic [DW-1:0]        QMAX   = DW'(1) << (C - 1);
  localparam logic signed [47:0]   RND48  = 48'((64'd1 << DUP) >> 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WMUL, S_PMUL, S_PSUM, S_SQ, S_NCHK, S_NORM, S_SQRT, S_DIV, S_DONE
  } state_t;

  state_t state;
  logic   issued;

  logic signed [C-1:0]  q  [4];
  logic signed [C-1:0]  qs [4];
  logic signed [15:0]   rate_x_r, rate_y_r, rate_z_r;
  logic [15:0]          step_r;
  logic signed [32:0]   w_x, w_y, w_z;
  logic [1:0]           comp;
  logic [1:0]           term_cnt;
  logic signed [AW-1:0] acc;
  logic [NW-1:0]        n;
  logic [RAD_W-1:0]     m;
  logic [5:0]           e;
  logic [ROOT_W-1:0]    r;
  logic                 degen;

  // Saturate a wide signed value to the component width
  function automatic logic signed [C-1:0] sat_c(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(CMAX_C);
    lo = AW'(CMIN_C);
    if (x > hi) return CMAX_C;
    if (x < lo) return CMIN_C;
    return x[C-1:0];
  endfunction

  // Convert a component to Q1.14, rounding half up and saturating
  function automatic logic signed [15:0] to_q14(input logic signed [C-1:0] x);
    logic signed [47:0] t;
    t = 48'(x);
    t = (t + RND48) >>> DUP;
    t = t <<< DDN;
    if (t > 48'sd32767) return 16'sh7fff;
    if (t < -48'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  // Convert a Q1.14 load value to the component format
  function automatic logic signed [C-1:0] from_q14(input logic signed [15:0] x);
    logic signed [47:0] t;
    t = 48'(x);
    t = t <<< DUP;
    t = t >>> DDN;
    return t[C-1:0];
  endfunction

  // Shared unit connections
  unit_stat_t                mul_stat, sqrt_stat, div_stat;
  logic                      mul_start, sqrt_start, div_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MB-1:0]      mul_b;
  logic signed [PW-1:0]      mul_prod;
  logic [ROOT_W-1:0]         sqrt_root;
  logic [DW-1:0]             div_num;
  logic [DW-1:0]             div_quot;

  term_t                term;
  logic [1:0]           q_sel;
  logic signed [C-1:0]  q_rd;
  logic signed [C-1:0]  qs_rd;
  logic signed [32:0]   w_rd;
  logic signed [15:0]   rate_rd;
  logic signed [AW-1:0] pterm;
  logic signed [AW-1:0] delta;
  logic signed [AW-1:0] psum;
  logic [C-1:0]         magc;
  logic [SH_W-1:0]      div_sh;
  logic [C-1:0]         qm;
  logic signed [C-1:0]  div_val;

  assign term  = term_of(comp, term_cnt);
  assign q_sel = (state == S_PSUM) ? comp : term.q_sel;
  assign q_rd  = q[q_sel];
  assign qs_rd = qs[comp];

  // Select the rate vector component for the current term
  always_comb begin
    case (term.w_sel)
      W_X:     w_rd = w_x;
      W_Y:     w_rd = w_y;
      default: w_rd = w_z;
    endcase
  end

  always_comb begin
    case (comp)
      W_X:     rate_rd = rate_x_r;
      W_Y:     rate_rd = rate_y_r;
      default: rate_rd = rate_z_r;
    endcase
  end

  // Route operands to the shared multiplier
  always_comb begin
    case (state)
      S_WMUL: begin
        mul_a = MUL_A_W'(rate_rd);
        mul_b = MB'($signed({1'b0, step_r}));
      end
      S_PMUL: begin
        mul_a = MUL_A_W'(w_rd);
        mul_b = MB'(q_rd);
      end
      S_SQ: begin
        mul_a = MUL_A_W'(qs_rd);
        mul_b = MB'(qs_rd);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start  = !issued && !mul_stat.busy &&
                      (state == S_WMUL || state == S_PMUL || state == S_SQ);
  assign sqrt_start = !issued && !sqrt_stat.busy && (state == S_SQRT);
  assign div_start  = !issued && !div_stat.busy && (state == S_DIV);

  // Product term divided by four, rounding down, and the rounded half sum
  assign pterm = AW'(mul_prod >>> 2);
  assign delta = (acc + HALF) >>> 26;
  assign psum  = AW'(q_rd) + delta;

  // Dividend for the normalizing divide
  assign magc    = qs_rd[C-1] ? C'(-qs_rd) : C'(qs_rd);
  assign div_sh  = SH_W'(magc) << e;
  assign div_num = (DW'(div_sh) << (FRAC - 1)) + DW'(r >> 1);
  assign qm      = (div_quot > QMAX) ? QMAX[C-1:0] : div_quot[C-1:0];
  assign div_val = (!qs_rd[C-1] && qm == QMAX[C-1:0]) ? CMAX_C :
                   (qs_rd[C-1] ? -$signed(qm) : $signed(qm));

  qai_mul #(.B_W(MB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  qai_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (m),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  qai_div #(.NUM_W(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign in_ready = (state == S_IDLE);

  // Sequencer, quaternion state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      q[0]      <= ONE_C;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
    end else begin
      // Drop valid once taken, unless a new result loads this cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action) begin
              q[0]  <= from_q14(load_real);
              q[1]  <= from_q14(load_i);
              q[2]  <= from_q14(load_j);
              q[3]  <= from_q14(load_k);
              degen <= 1'b0;
              state <= S_DONE;
            end else begin
              rate_x_r <= rate_x;
              rate_y_r <= rate_y;
              rate_z_r <= rate_z;
              step_r   <= step_time;
              comp     <= '0;
              state    <= S_WMUL;
            end
          end
        end
        S_WMUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (mul_stat.done) begin
            issued <= 1'b0;
            case (comp)
              W_X:     w_x <= mul_prod[32:0];
              W_Y:     w_y <= mul_prod[32:0];
              default: w_z <= mul_prod[32:0];
            endcase
            if (comp == W_Z) begin
              comp     <= '0;
              term_cnt <= '0;
              acc      <= '0;
              state    <= S_PMUL;
            end else begin
              comp <= comp + 1'b1;
            end
          end
        end
        S_PMUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (mul_stat.done) begin
            issued <= 1'b0;
            acc    <= term.neg ? acc - pterm : acc + pterm;
            if (term_cnt == 2'd2) begin
              term_cnt <= '0;
              state    <= S_PSUM;
            end else begin
              term_cnt <= term_cnt + 1'b1;
            end
          end
        end
        S_PSUM: begin
          qs[comp] <= sat_c(psum);
          acc      <= '0;
          if (comp == Q_K) begin
            comp  <= '0;
            n     <= '0;
            state <= S_SQ;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_PMUL;
          end
        end
        S_SQ: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (mul_stat.done) begin
            issued <= 1'b0;
            n      <= n + mul_prod[NW+1:2];
            if (comp == Q_K) begin
              state <= S_NCHK;
            end else begin
              comp <= comp + 1'b1;
            end
          end
        end
        S_NCHK: begin
          if (n < N_MIN) begin
            q[0]  <= ONE_C;
            q[1]  <= qs[1];
            q[2]  <= qs[2];
            q[3]  <= qs[3];
            degen <= 1'b1;
            state <= S_DONE;
          end else begin
            m     <= RAD_W'(n);
            e     <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Scale the norm up by fours until it reaches the root unit's range
          if (m < M_LOW) begin
            m <= m << 2;
            e <= e + 1'b1;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (sqrt_stat.done) begin
            issued <= 1'b0;
            r      <= sqrt_root;
            comp   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (div_stat.done) begin
            issued  <= 1'b0;
            q[comp] <= div_val;
            if (comp == Q_K) begin
              degen <= 1'b0;
              state <= S_DONE;
            end else begin
              comp <= comp + 1'b1;
            end
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_real   <= to_q14(q[0]);
            out_i      <= to_q14(q[1]);
            out_j      <= to_q14(q[2]);
            out_k      <= to_q14(q[3]);
            degenerate <= degen;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/qai_checker.sv
// Port-level checks for the quaternion attitude integrator, bound to the top.
// Depends on quaternion_attitude_integrator_core for the bind target.
`default_nettype none

module qai_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_real,
  input wire logic signed [15:0] out_i,
  input wire logic signed [15:0] out_j,
  input wire logic signed [15:0] out_k,
  input wire logic               degenerate
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_real) && $stable(out_i) &&
                                 $stable(out_j) && $stable(out_k) && $stable(degenerate))
    else $error("stalled result changed");

  // A degenerate result carries a real part of exactly one
  a_degen_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> out_real == 16'sd16384)
    else $error("degenerate result without unit real part");

  // One transaction in flight: drop ready right after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

bind quaternion_attitude_integrator_core qai_checker u_qai_checker (.*);

`default_nettype wire

### tb/quaternion_attitude_integrator_core_tb.sv
// Testbench for quaternion_attitude_integrator_core: directed table, then random traffic.
// Self-checking against a bit-exact attitude predictor. Depends on the core RTL and qai_pkg.
`default_nettype none

module quaternion_attitude_integrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam longint CMAX = 32767;
  localparam longint CMIN = -32768;
  localparam int N_RANDOM = 1525;
  localparam longint LIMIT = 12_000_000;
  localparam logic ACT_INTEGRATE = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct {
    logic               action;
    logic signed [15:0] rx, ry, rz;
    logic [15:0]        dt;
    logic signed [15:0] lr, li, lj, lk;
  } attitude_cmd_t;

  typedef struct {
    logic signed [15:0] q_r, q_i, q_j, q_k;
    logic               degen;
  } attitude_out_t;

  typedef struct {
    attitude_cmd_t cmd;
    bit            fixed;
    attitude_out_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
  logic [15:0] step_time = '0;
  logic signed [15:0] load_real = '0, load_i = '0, load_j = '0, load_k = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_real, out_i, out_j, out_k;
  logic degenerate;

  quaternion_attitude_integrator_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z), .step_time(step_time),
    .load_real(load_real), .load_i(load_i), .load_j(load_j), .load_k(load_k),
    .out_valid(out_valid), .out_ready(out_ready), .out_real(out_real), .out_i(out_i),
    .out_j(out_j), .out_k(out_k), .degenerate(degenerate)
  );

  // Predictor state: stored attitude quaternion
  longint att_r, att_i, att_j, att_k;
  attitude_out_t pending_att[$];
  bit            pending_fixed[$];
  table_row_t    dir_rows[$];
  int  mismatches = 0;
  longint cycles = 0;
  bit  hold_off_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat(input longint x);
    return x < CMIN ? CMIN : (x > CMAX ? CMAX : x);
  endfunction

  function automatic longint unsigned magn(input longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint renorm(input longint c, input int sh, input longint unsigned r);
    longint unsigned m;
    longint v;
    m = ((magn(c) << sh) + (r >> 1)) / r;
    v = (m > 64'd32768) ? 32768 : longint'(m);
    return sat(c < 0 ? -v : v);
  endfunction

  // Advance the stored attitude by one transaction and return the output it shows
  function automatic attitude_out_t advance_attitude(input attitude_cmd_t c);
    attitude_out_t o;
    longint wx, wy, wz, sr, si, sj, sk, qr, qi, qj, qk;
    longint unsigned n, m, r;
    int e;
    o.degen = 1'b0;
    if (c.action == ACT_LOAD) begin
      att_r = c.lr; att_i = c.li; att_j = c.lj; att_k = c.lk;
    end else begin
      wx = longint'(c.rx) * longint'({1'b0, c.dt});
      wy = longint'(c.ry) * longint'({1'b0, c.dt});
      wz = longint'(c.rz) * longint'({1'b0, c.dt});
      sr = -((wx * att_i) >>> 2) - ((wy * att_j) >>> 2) - ((wz * att_k) >>> 2);
      si = ((wx * att_r) >>> 2) + ((wy * att_k) >>> 2) - ((wz * att_j) >>> 2);
      sj = ((wy * att_r) >>> 2) + ((wz * att_i) >>> 2) - ((wx * att_k) >>> 2);
      sk = ((wz * att_r) >>> 2) + ((wx * att_j) >>> 2) - ((wy * att_i) >>> 2);
      qr = sat(att_r + ((sr + (64'sd1 <<< 25)) >>> 26));
      qi = sat(att_i + ((si + (64'sd1 <<< 25)) >>> 26));
      qj = sat(att_j + ((sj + (64'sd1 <<< 25)) >>> 26));
      qk = sat(att_k + ((sk + (64'sd1 <<< 25)) >>> 26));
      n = ((magn(qr) * magn(qr)) >> 2) + ((magn(qi) * magn(qi)) >> 2)
        + ((magn(qj) * magn(qj)) >> 2) + ((magn(qk) * magn(qk)) >> 2);
      if (n < (64'd1 << (FRAC - 2))) begin
        // Norm collapsed: force the real part to one
        att_r = 64'sd1 <<< FRAC; att_i = qi; att_j = qj; att_k = qk;
        o.degen = 1'b1;
      end else begin
        m = n;
        e = 0;
        while (m < (64'd1 << 60)) begin
          m <<= 2;
          e++;
        end
        r = root_floor(m);
        att_r = renorm(qr, e + FRAC - 1, r);
        att_i = renorm(qi, e + FRAC - 1, r);
        att_j = renorm(qj, e + FRAC - 1, r);
        att_k = renorm(qk, e + FRAC - 1, r);
      end
    end
    o.q_r = att_r[15:0]; o.q_i = att_i[15:0]; o.q_j = att_j[15:0]; o.q_k = att_k[15:0];
    return o;
  endfunction

  function automatic attitude_cmd_t mk_cmd(input logic act, input int rx, input int ry,
                                           input int rz, input int dt, input int lr,
                                           input int li, input int lj, input int lk);
    attitude_cmd_t c;
    c.action = act; c.rx = rx; c.ry = ry; c.rz = rz; c.dt = dt;
    c.lr = lr; c.li = li; c.lj = lj; c.lk = lk;
    return c;
  endfunction

  function automatic attitude_out_t mk_out(input int r, input int i, input int j,
                                           input int k, input logic d);
    attitude_out_t o;
    o.q_r = r; o.q_i = i; o.q_j = j; o.q_k = k; o.degen = d;
    return o;
  endfunction

  function automatic int rand_s16(input bit narrow);
    if (narrow) return $signed($urandom_range(0, 1024)) - 512;
    return $signed(16'($urandom));
  endfunction

  function automatic attitude_cmd_t rand_cmd();
    attitude_cmd_t c;
    int pick;
    c = mk_cmd(ACT_INTEGRATE, rand_s16(0), rand_s16(0), rand_s16(0), $urandom,
               rand_s16(0), rand_s16(0), rand_s16(0), rand_s16(0));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c.action = ACT_LOAD;
      // Some unit-like loads, some tiny ones that can collapse the norm, the rest random
      if (pick < 8) begin
        c.lr = 16384 + rand_s16(1); c.li = rand_s16(1) * 8;
        c.lj = rand_s16(1) * 8; c.lk = rand_s16(1) * 8;
      end else if (pick < 11) begin
        c.lr = $signed($urandom_range(0, 60)) - 30; c.li = $signed($urandom_range(0, 60)) - 30;
        c.lj = $signed($urandom_range(0, 60)) - 30; c.lk = $signed($urandom_range(0, 60)) - 30;
      end
    end else if (pick < 75) begin
      // Realistic small rotations
      c.rx = rand_s16(1) * ($urandom_range(1, 8)); c.ry = rand_s16(1) * ($urandom_range(1, 8));
      c.rz = rand_s16(1) * ($urandom_range(1, 8)); c.dt = $urandom_range(0, 2000);
    end
    return c;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic offer_cmd(input attitude_cmd_t c);
    int gap;
    action <= c.action; rate_x <= c.rx; rate_y <= c.ry; rate_z <= c.rz;
    step_time <= c.dt; load_real <= c.lr; load_i <= c.li; load_j <= c.lj; load_k <= c.lk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = ($urandom_range(0, 9) < 4) ? 0 :
          ($urandom_range(0, 19) == 0 ? $urandom_range(50, 400) : $urandom_range(1, 6));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check results and record expectations at each edge
  always @(posedge clk) begin
    attitude_out_t w;
    attitude_cmd_t c;
    bit fx;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_att.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        w = pending_att.pop_front();
        fx = pending_fixed.pop_front();
        if (w.q_r !== out_real || w.q_i !== out_i || w.q_j !== out_j || w.q_k !== out_k ||
            w.degen !== degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch%s: want %0d %0d %0d %0d d%0b got %0d %0d %0d %0d d%0b",
                     fx ? " (table)" : "", w.q_r, w.q_i, w.q_j, w.q_k, w.degen,
                     out_real, out_i, out_j, out_k, degenerate);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      c = mk_cmd(action, rate_x, rate_y, rate_z, step_time, load_real, load_i, load_j, load_k);
      w = advance_attitude(c);
      if (dir_rows.size() > 0 && dir_rows[0].fixed) w = dir_rows[0].want;
      fx = dir_rows.size() > 0 && dir_rows[0].fixed;
      if (dir_rows.size() > 0) void'(dir_rows.pop_front());
      pending_att.push_back(w);
      pending_fixed.push_back(fx);
    end
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off during the random phase
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_off_done && cycles > 60_000) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 3) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  // Sender: directed table, then random traffic
  initial begin
    table_row_t row;
    table_row_t rows[$];
    attitude_cmd_t c;
    int k;
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_out(16384, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 32767, -32768, 0, 1), 1,
                     mk_out(32767, -32768, 0, 1, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, -1, -1, -1, 65535, -32768, 32767, -1, 0), 1,
                     mk_out(-32768, 32767, -1, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 100, 100, 100, 100, 0, 0, 0, 0), 1,
                     mk_out(16384, 0, 0, 0, 1)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 5, -7, 3, 2), 1, mk_out(5, -7, 3, 2, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0, 0, 0), 0, mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 16384, 0, 0, 0), 1,
                     mk_out(16384, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 32767, 32767, 32767, 65535, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, -32768, -32768, -32768, 65535, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 32767, -32768, 0, 1, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 2048, 0, 0, 655, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 0, -2048, 0, 655, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 0, 0, 2048, 65535, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 32767, 32767, 32767, 32767), 1,
                     mk_out(32767, 32767, 32767, 32767, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 32767, 32767, 32767, 65535, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, -32768, -32768, -32768, -32768), 1,
                     mk_out(-32768, -32768, -32768, -32768, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, -32768, 32767, -32768, 65535, 0, 0, 0, 0), 0,
                     mk_out(0, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_LOAD, 0, 0, 0, 0, 1, 0, 0, 0), 1, mk_out(1, 0, 0, 0, 0)});
    rows.push_back('{mk_cmd(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_out(16384, 0, 0, 0, 1)});
    att_r = 16384; att_i = 0; att_j = 0; att_k = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed rows
    foreach (rows[k]) dir_rows.push_back(rows[k]);
    foreach (rows[k]) offer_cmd(rows[k].cmd);
    // Random traffic, with one pause that drains the block
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_att.size() != 0) @(posedge clk);
      end
      c = rand_cmd();
      offer_cmd(c);
    end
    in_valid <= 1'b0;
    while (pending_att.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (mismatches == 0 && pending_att.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/qai_pkg.sv
design/qai_mul.sv
design/qai_isqrt.sv
design/qai_div.sv
design/quaternion_attitude_integrator_core.sv
design/qai_checker.sv
tb/quaternion_attitude_integrator_core_tb.sv
